// ===== rtl/utf8_to_utf16_decoder_core_defines.svh =====
// Assertion macros shared by the transcoder checker.
// No dependencies; pulled in by files that hold concurrent assertions.
`ifndef UTF8_TO_UTF16_DECODER_CORE_DEFINES_SVH
`define UTF8_TO_UTF16_DECODER_CORE_DEFINES_SVH

// Checked on every clock edge outside reset.
`define UTD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define UTD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/utf8u16_pkg.sv =====
// Types, constants and helpers for the UTF-8 to UTF-16 transcoder.
// No dependencies; used by the decode step, the top level, the checker and the testbench.
`default_nettype none

package utf8u16_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        last_of_run;
   } rsp_type;

   // Pending multi-byte sequence; exp_len of zero means none pending.
   typedef struct packed {
      logic [2:0]  exp_len;
      logic [2:0]  seen;
      logic [20:0] acc;
   } dec_state_type;

   localparam logic [15:0] REPLACEMENT_CHAR = 16'hFFFD;
   localparam logic [20:0] MAX_CODE_POINT   = 21'h10FFFF;
   localparam logic [20:0] SURR_LOW_START   = 21'h00D800;
   localparam logic [20:0] SURR_HIGH_END    = 21'h00DFFF;
   localparam logic [20:0] BMP_MAX          = 21'h00FFFF;
   localparam logic [20:0] SUPP_BASE        = 21'h010000;
   localparam logic [15:0] SURR_LEAD_BASE   = 16'hD800;
   localparam logic [15:0] SURR_TRAIL_BASE  = 16'hDC00;

   localparam logic [2:0] LEN_NONE = 3'd0;
   localparam logic [2:0] LEN_TWO  = 3'd2;
   localparam logic [2:0] LEN_THREE = 3'd3;
   localparam logic [2:0] LEN_FOUR = 3'd4;

   localparam int unsigned MAX_UNITS = 4;

   // Smallest code point that a sequence of the given length may carry.
   function automatic logic [20:0] min_value(input logic [2:0] len);
      logic [20:0] v;
      unique case (len)
         LEN_TWO:   v = 21'h000080;
         LEN_THREE: v = 21'h000800;
         LEN_FOUR:  v = 21'h010000;
         default:   v = 21'h000000;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/utf8u16_decode.sv =====
// One-byte decode step: pending state plus one byte gives up to four units.
// Depends on utf8u16_pkg.
`default_nettype none

module utf8u16_decode (
   input  utf8u16_pkg::dec_state_type st,
   input  utf8u16_pkg::req_type       req,
   output utf8u16_pkg::dec_state_type st_next,
   output logic [2:0]                 unit_cnt,
   output logic [3:0][15:0]           units
);

   logic [7:0]  b;
   logic        is_cont;
   logic [20:0] acc_new;
   logic [2:0]  seen_new;
   logic [20:0] supp;
   logic        bad_value;
   logic        fresh;
   logic [2:0]  lead_len;
   logic [20:0] lead_payload;

   assign b        = req.data_byte;
   assign is_cont  = (b[7:6] == 2'b10);
   assign acc_new  = {st.acc[14:0], b[5:0]};
   assign seen_new = st.seen + 3'd1;
   assign supp     = acc_new - utf8u16_pkg::SUPP_BASE;

   assign bad_value = (acc_new < utf8u16_pkg::min_value(st.exp_len)) ||
                      (acc_new > utf8u16_pkg::MAX_CODE_POINT) ||
                      ((acc_new >= utf8u16_pkg::SURR_LOW_START) &&
                       (acc_new <= utf8u16_pkg::SURR_HIGH_END));

   always_comb begin
      priority casez (b)
         8'b110?????: begin
            lead_len     = utf8u16_pkg::LEN_TWO;
            lead_payload = {16'h0000, b[4:0]};
         end
         8'b1110????: begin
            lead_len     = utf8u16_pkg::LEN_THREE;
            lead_payload = {17'h00000, b[3:0]};
         end
         8'b11110???: begin
            lead_len     = utf8u16_pkg::LEN_FOUR;
            lead_payload = {18'h00000, b[2:0]};
         end
         default: begin
            lead_len     = utf8u16_pkg::LEN_NONE;
            lead_payload = '0;
         end
      endcase
   end

   always_comb begin
      st_next  = st;
      unit_cnt = 3'd0;
      fresh    = 1'b1;
      for (int i = 0; i < utf8u16_pkg::MAX_UNITS; i++) begin
         units[i] = utf8u16_pkg::REPLACEMENT_CHAR;
      end

      if (st.exp_len != utf8u16_pkg::LEN_NONE) begin
         if (is_cont) begin
            fresh       = 1'b0;
            st_next.acc  = acc_new;
            st_next.seen = seen_new;
            if (seen_new >= st.exp_len) begin
               st_next = '0;
               if (bad_value) begin
                  unit_cnt = 3'd1;
               end else if (acc_new <= utf8u16_pkg::BMP_MAX) begin
                  units[0] = acc_new[15:0];
                  unit_cnt = 3'd1;
               end else begin
                  units[0] = utf8u16_pkg::SURR_LEAD_BASE + {6'b0, supp[19:10]};
                  units[1] = utf8u16_pkg::SURR_TRAIL_BASE + {6'b0, supp[9:0]};
                  unit_cnt = 3'd2;
               end
            end else if (req.end_of_text) begin
               // truncated by end of text: one replacement per byte received
               st_next  = '0;
               unit_cnt = (seen_new > 3'd4) ? 3'd4 : seen_new;
            end
         end else begin
            // broken sequence: flush pending bytes, then decode this byte anew
            st_next  = '0;
            unit_cnt = (st.seen > 3'd3) ? 3'd3 : st.seen;
         end
      end

      if (fresh) begin
         if (!b[7]) begin
            units[unit_cnt[1:0]] = {8'h00, b};
            unit_cnt = unit_cnt + 3'd1;
         end else if ((lead_len == utf8u16_pkg::LEN_NONE) || req.end_of_text) begin
            units[unit_cnt[1:0]] = utf8u16_pkg::REPLACEMENT_CHAR;
            unit_cnt = unit_cnt + 3'd1;
         end else begin
            st_next.exp_len = lead_len;
            st_next.seen    = 3'd1;
            st_next.acc     = lead_payload;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/utf8_to_utf16_decoder_core.sv =====
// UTF-8 to UTF-16 transcoder, top level.
// Depends on utf8u16_pkg and utf8u16_decode.
//
// Usage:
//   req_ channel: one UTF-8 byte per request, end_of_text on the final byte
//   flushes any partial sequence. rsp_ channel: UTF-16 code units, with
//   last_of_run set on the final unit that a byte produced (bytes that only
//   open or extend a sequence produce none).
//   Path: a request is held in the input register, decoded from there, and
//   its units are written into the result buffer that drives rsp_.
//   Throughput: one byte per cycle while each byte yields at most one unit and rsp_ is not stalled.
//   A byte yielding k units holds the four-entry result buffer until all k have gone,
//   since the rsp_ port moves one unit per cycle while not stalled; the one-deep input register
//   then raises req_stall until the buffer drains.
//   A stalled rsp_ keeps its unit steady; the input register still takes one
//   more request before req_stall rises.
//   Reset (synchronous, active high) drops any pending sequence and empties
//   the input register and the result buffer.
`default_nettype none

module utf8_to_utf16_decoder_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  utf8u16_pkg::req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output utf8u16_pkg::rsp_type rsp_payload
);

   logic                       in_valid_ff, in_valid_in;
   utf8u16_pkg::req_type       in_data_ff, in_data_in;
   utf8u16_pkg::dec_state_type state_ff, state_in;
   logic [2:0]                 out_cnt_ff, out_cnt_in;
   logic [3:0][15:0]           out_units_ff, out_units_in;

   utf8u16_pkg::dec_state_type dec_next;
   logic [2:0]                 dec_cnt;
   logic [3:0][15:0]           dec_units;

   logic rsp_take, req_take, out_free, advance;

   utf8u16_decode u_decode (
      .st       (state_ff),
      .req      (in_data_ff),
      .st_next  (dec_next),
      .unit_cnt (dec_cnt),
      .units    (dec_units)
   );

   assign rsp_valid = (out_cnt_ff != 3'd0);
   assign rsp_take  = rsp_valid & ~rsp_stall;
   // buffer can take a new run once its last unit leaves this cycle
   assign out_free  = (out_cnt_ff == 3'd0) || ((out_cnt_ff == 3'd1) && rsp_take);
   assign advance   = in_valid_ff & out_free;
   assign req_stall = in_valid_ff & ~out_free;
   assign req_take  = req_valid & ~req_stall;

   assign rsp_payload.code_unit   = out_units_ff[0];
   assign rsp_payload.last_of_run = (out_cnt_ff == 3'd1);

   always_comb begin
      in_valid_in  = req_take | (in_valid_ff & ~advance);
      in_data_in   = req_take ? req_payload : in_data_ff;
      state_in     = advance ? dec_next : state_ff;
      out_cnt_in   = out_cnt_ff;
      out_units_in = out_units_ff;
      if (advance) begin
         out_cnt_in   = dec_cnt;
         out_units_in = dec_units;
      end else if (rsp_take) begin
         out_cnt_in   = out_cnt_ff - 3'd1;
         out_units_in = {16'h0000, out_units_ff[3:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '0;
         out_cnt_ff  <= 3'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
         out_cnt_ff  <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff   <= in_data_in;
      out_units_ff <= out_units_in;
   end

endmodule

`default_nettype wire

// ===== rtl/utf8u16_checker.sv =====
// Port-level checks for the transcoder, bound to the top level.
// Depends on utf8u16_pkg and utf8_to_utf16_decoder_core_defines.svh.
`default_nettype none
`include "utf8_to_utf16_decoder_core_defines.svh"

module utf8u16_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_stall,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire utf8u16_pkg::rsp_type rsp_payload
);

   `UTD_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "rsp_valid after reset")

   // input side only backs up behind a unit waiting at the output
   `UTD_ASSERT(a_stall_cause, clock, reset, req_stall |-> rsp_valid, "req_stall with no unit")

   // a run keeps going until its last unit has gone out
   `UTD_ASSERT(a_run_cont, clock, reset,
      (rsp_valid && !rsp_stall && !rsp_payload.last_of_run) |=> rsp_valid,
      "run ended early")

   `UTD_ASSERT(a_rsp_hold, clock, reset,
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)),
      "stalled unit changed")

endmodule

bind utf8_to_utf16_decoder_core utf8u16_checker u_checker (.*);

`default_nettype wire

// ===== tb/tb_utf8_to_utf16_decoder_core.sv =====
// Self-checking testbench for utf8_to_utf16_decoder_core: drives UTF-8 bytes,
// predicts the UTF-16 code units and compares them as they leave the rsp_ port.
// Depends on utf8u16_pkg and the utf8_to_utf16_decoder_core RTL.
`timescale 1ns / 100ps
`default_nettype none

module tb_utf8_to_utf16_decoder_core;

   typedef struct {
      utf8u16_pkg::req_type req;
      int                   gap_pct;
      bit                   drain_first;
      bit                   hold_rsp;
   } queued_byte_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   utf8u16_pkg::req_type req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   utf8u16_pkg::rsp_type rsp_payload;

   queued_byte_type      input_bytes [$];
   utf8u16_pkg::rsp_type expected_units [$];

   // decoder state mirrored from the block
   logic [2:0]  seq_len = utf8u16_pkg::LEN_NONE;
   logic [2:0]  seq_seen = 3'd0;
   logic [20:0] seq_acc = '0;

   int  error_count = 0;
   bit  req_taken = 1'b0;
   int  req_gap_left = 0;
   bit  req_gap_spent = 1'b0;
   int  rsp_stall_left = 0;
   bit  rsp_stall_spent = 1'b0;
   int  rsp_idle_pct = 0;
   int  long_holds_wanted = 0;
   int  long_holds_done = 0;
   int  long_hold_left = 0;
   queued_byte_type      next_byte;
   utf8u16_pkg::rsp_type want_unit;

   // settings applied to bytes as the stimulus is queued
   int  fill_gap_pct = 0;
   bit  fill_drain = 1'b0;
   bit  fill_hold = 1'b0;

   utf8_to_utf16_decoder_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Work out the code units one accepted byte produces.
   task automatic decode_utf8_byte(input utf8u16_pkg::req_type r);
      logic [15:0]          units [0:3];
      int                   n;
      bit                   fresh;
      logic [2:0]           lead_len;
      logic [20:0]          lead_bits;
      logic [20:0]          lowest;
      logic [20:0]          offset;
      utf8u16_pkg::rsp_type unit_item;
      n = 0;
      fresh = 1'b1;
      if (seq_len != utf8u16_pkg::LEN_NONE) begin
         if (r.data_byte[7:6] == 2'b10) begin
            fresh = 1'b0;
            seq_acc = {seq_acc[14:0], r.data_byte[5:0]};
            seq_seen = seq_seen + 3'd1;
            if (seq_seen >= seq_len) begin
               case (seq_len)
                  utf8u16_pkg::LEN_TWO:   lowest = 21'h000080;
                  utf8u16_pkg::LEN_THREE: lowest = 21'h000800;
                  default:                lowest = 21'h010000;
               endcase
               if (seq_acc < lowest || seq_acc > utf8u16_pkg::MAX_CODE_POINT ||
                   (seq_acc >= utf8u16_pkg::SURR_LOW_START &&
                    seq_acc <= utf8u16_pkg::SURR_HIGH_END)) begin
                  units[n] = utf8u16_pkg::REPLACEMENT_CHAR;
                  n++;
               end else if (seq_acc <= utf8u16_pkg::BMP_MAX) begin
                  units[n] = seq_acc[15:0];
                  n++;
               end else begin
                  offset = seq_acc - utf8u16_pkg::SUPP_BASE;
                  units[n] = utf8u16_pkg::SURR_LEAD_BASE + {6'd0, offset[19:10]};
                  units[n + 1] = utf8u16_pkg::SURR_TRAIL_BASE + {6'd0, offset[9:0]};
                  n += 2;
               end
               seq_len = utf8u16_pkg::LEN_NONE;
            end else if (r.end_of_text) begin
               repeat (seq_seen) begin
                  units[n] = utf8u16_pkg::REPLACEMENT_CHAR;
                  n++;
               end
               seq_len = utf8u16_pkg::LEN_NONE;
            end
         end else begin
            // broken sequence: one replacement per pending byte
            repeat (seq_seen) begin
               units[n] = utf8u16_pkg::REPLACEMENT_CHAR;
               n++;
            end
            seq_len = utf8u16_pkg::LEN_NONE;
         end
         if (seq_len == utf8u16_pkg::LEN_NONE) begin
            seq_seen = 3'd0;
            seq_acc = '0;
         end
      end
      if (fresh) begin
         if (!r.data_byte[7]) begin
            units[n] = {8'h00, r.data_byte};
            n++;
         end else begin
            lead_len = utf8u16_pkg::LEN_NONE;
            lead_bits = '0;
            if (r.data_byte[7:5] == 3'b110) begin
               lead_len = utf8u16_pkg::LEN_TWO;
               lead_bits = {16'd0, r.data_byte[4:0]};
            end else if (r.data_byte[7:4] == 4'b1110) begin
               lead_len = utf8u16_pkg::LEN_THREE;
               lead_bits = {17'd0, r.data_byte[3:0]};
            end else if (r.data_byte[7:3] == 5'b11110) begin
               lead_len = utf8u16_pkg::LEN_FOUR;
               lead_bits = {18'd0, r.data_byte[2:0]};
            end
            if (lead_len == utf8u16_pkg::LEN_NONE || r.end_of_text) begin
               units[n] = utf8u16_pkg::REPLACEMENT_CHAR;
               n++;
            end else begin
               seq_len = lead_len;
               seq_seen = 3'd1;
               seq_acc = lead_bits;
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         unit_item.code_unit = units[i];
         unit_item.last_of_run = (i == n - 1);
         expected_units.insert(expected_units.size(), unit_item);
      end
   endtask

   task automatic add_byte(input logic [7:0] b, input bit eot);
      queued_byte_type q;
      q.req.data_byte = b;
      q.req.end_of_text = eot;
      q.gap_pct = fill_gap_pct;
      q.drain_first = fill_drain;
      q.hold_rsp = fill_hold;
      input_bytes.insert(input_bytes.size(), q);
      fill_drain = 1'b0;
      fill_hold = 1'b0;
   endtask

   function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input int len,
                                            input int idx);
      logic [20:0] shifted;
      if (idx == 0) begin
         case (len)
            1:       return {1'b0, cp[6:0]};
            2:       return {3'b110, cp[10:6]};
            3:       return {4'b1110, cp[15:12]};
            default: return {5'b11110, cp[20:18]};
         endcase
      end
      shifted = cp >> (6 * (len - 1 - idx));
      return {2'b10, shifted[5:0]};
   endfunction

   // First 'count' bytes of a 'len'-byte encoding; eot on the last one queued.
   task automatic add_code_point(input logic [20:0] cp, input int len, input int count,
                                 input bit eot);
      for (int i = 0; i < count; i++)
         add_byte(utf8_byte(cp, len, i), eot && (i == count - 1));
   endtask

   task automatic add_random_piece();
      int          kind;
      int          len;
      bit          eot;
      logic [20:0] cp;
      kind = $urandom_range(99);
      eot = ($urandom_range(9) == 0);
      len = $urandom_range(1, 4);
      if (kind < 55) begin
         // well-formed character, though a three-byte one may land among the surrogates
         case (len)
            1:       cp = 21'($urandom_range(21'h00007F));
            2:       cp = 21'($urandom_range(21'h0007FF, 21'h000080));
            3:       cp = 21'($urandom_range(21'h00FFFF, 21'h000800));
            default: cp = 21'($urandom_range(21'h10FFFF, 21'h010000));
         endcase
         add_code_point(cp, len, len, eot);
      end else if (kind < 80) begin
         // right shape, any payload: overlong, surrogate, out of range
         cp = 21'($urandom);
         len = $urandom_range(2, 4);
         add_code_point(cp, len, len, eot);
      end else if (kind < 90) begin
         // truncated, broken by whatever follows or ended by end of text
         cp = 21'($urandom);
         len = $urandom_range(2, 4);
         add_code_point(cp, len, $urandom_range(1, len - 1), eot);
      end else begin
         add_byte(8'($urandom_range(255)), eot);
      end
   endtask

   // request side: note what the block accepted and predict its output
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         decode_utf8_byte(req_payload);
         req_taken <= 1'b1;
      end else begin
         req_taken <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap_left > 0) begin
            req_gap_left = req_gap_left - 1;
            req_valid <= 1'b0;
         end else if (input_bytes.size() == 0 ||
                      (input_bytes[0].drain_first && expected_units.size() != 0)) begin
            req_valid <= 1'b0;
         end else if (!req_gap_spent && $urandom_range(99) < input_bytes[0].gap_pct) begin
            req_gap_left = $urandom_range(11);
            req_gap_spent = 1'b1;
            req_valid <= 1'b0;
         end else begin
            next_byte = input_bytes.pop_front();
            req_gap_spent = 1'b0;
            req_valid <= 1'b1;
            req_payload <= next_byte.req;
            rsp_idle_pct <= next_byte.gap_pct;
            if (next_byte.hold_rsp)
               long_holds_wanted <= long_holds_wanted + 1;
         end
      end
   end

   // result side: random stall bursts plus the occasional long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (long_hold_left > 0) begin
         long_hold_left = long_hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (long_holds_done != long_holds_wanted) begin
         long_holds_done = long_holds_done + 1;
         long_hold_left = 79;
         rsp_stall <= 1'b1;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left = rsp_stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (!rsp_stall_spent && $urandom_range(99) < rsp_idle_pct) begin
         rsp_stall_left = $urandom_range(11);
         rsp_stall_spent = 1'b1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall_spent = 1'b0;
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_units.size() == 0) begin
            $display("%0t: unexpected unit: expected none, got %h last %b",
                     $time, rsp_payload.code_unit, rsp_payload.last_of_run);
            error_count++;
         end else begin
            want_unit = expected_units.pop_front();
            if (rsp_payload.code_unit !== want_unit.code_unit) begin
               $display("%0t: code_unit mismatch: expected %h, got %h",
                        $time, want_unit.code_unit, rsp_payload.code_unit);
               error_count++;
            end
            if (rsp_payload.last_of_run !== want_unit.last_of_run) begin
               $display("%0t: last_of_run mismatch: expected %b, got %b",
                        $time, want_unit.last_of_run, rsp_payload.last_of_run);
               error_count++;
            end
         end
      end
   end

   initial begin
      // directed text
      fill_gap_pct = 15;
      add_byte(8'h00, 1'b0);
      add_byte(8'hFF, 1'b0);                                          // invalid lead
      add_byte(8'hC0, 1'b0); add_byte(8'hAF, 1'b0);                   // overlong
      add_byte(8'hE2, 1'b0); add_byte(8'h82, 1'b0); add_byte(8'hAC, 1'b0);
      add_byte(8'hED, 1'b0); add_byte(8'hA0, 1'b0); add_byte(8'h80, 1'b0); // surrogate
      add_byte(8'hF0, 1'b0); add_byte(8'h9F, 1'b0); add_byte(8'h98, 1'b0);
      add_byte(8'h80, 1'b0);                                          // pair
      add_byte(8'hF4, 1'b0); add_byte(8'h90, 1'b0); add_byte(8'h80, 1'b0);
      add_byte(8'h80, 1'b0);                                          // above max
      add_byte(8'h80, 1'b0);                                          // stray continuation
      add_byte(8'hF8, 1'b0);                                          // invalid lead
      add_byte(8'hE2, 1'b0); add_byte(8'h82, 1'b0); add_byte(8'h41, 1'b0); // broken
      add_byte(8'hE2, 1'b0); add_byte(8'h82, 1'b1);                   // eot mid-sequence
      add_byte(8'hC3, 1'b1);                                          // lead at eot

      // random text in phases
      fill_gap_pct = 25;
      while (input_bytes.size() < 110)
         add_random_piece();
      // receiver holds off once while the sender keeps going
      fill_gap_pct = 0;
      fill_hold = 1'b1;
      while (input_bytes.size() < 160)
         add_random_piece();
      // sender waits for the pipe to empty before the first byte of this phase
      fill_gap_pct = 40;
      fill_drain = 1'b1;
      while (input_bytes.size() < 225)
         add_random_piece();
      fill_gap_pct = 0;
      while (input_bytes.size() < 270)
         add_random_piece();

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (input_bytes.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_units.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("utf8_to_utf16_decoder_core test passed");
      else
         $display("utf8_to_utf16_decoder_core test failed");
      $finish;
   end

   initial begin
      #400000;
      $display("utf8_to_utf16_decoder_core test failed");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/utf8u16_pkg.sv
rtl/utf8u16_decode.sv
rtl/utf8_to_utf16_decoder_core.sv
rtl/utf8u16_checker.sv
tb/tb_utf8_to_utf16_decoder_core.sv
